// ===== rtl/rcp_pkg.sv =====
// Shared types and constants for the reference-counted context pool.
// No dependencies; imported by refcounted_context_pool.
package rcp_pkg;

   localparam int KEY_W              = 32;
   localparam int DATA_W             = 16;
   localparam int POOL_SIZE_W        = 5;
   localparam int IDX_OUT_W          = 4;
   localparam int STATUS_W           = 2;
   localparam int POOL_DEPTH_DEFAULT = 16;

   localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 5'd16;
   localparam logic [DATA_W-1:0]      COUNT_MAX       = 16'hFFFF;
   localparam logic [DATA_W-1:0]      COUNT_ONE       = 16'd1;

   // operation codes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED   = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_SCAN    = 3'b010,
      S_RELEASE = 3'b100
   } state_type;

   // one pool entry as stored in the table memory
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] stride;
      logic [DATA_W-1:0] size;
   } entry_type;

endpackage

// ===== rtl/refcounted_context_pool.sv =====
// Reference-counted context pool: table memory, live bits and scan sequencer.
// Depends on rcp_pkg for the entry layout, state codes and status codes.
//
//   port group | direction | handshake         | payload
//   -----------+-----------+-------------------+-------------------------------------------
//   req_       | in        | start / busy      | op, team key, layout, release index
//   rsp_       | out       | rsp_valid strobe  | index, count, new flag, layout, status
//   csr_       | in        | csr_wr_en         | pool_size (entries in use)
//
// Acquire: the scan reads the entries in use (pool_size limited to POOL_DEPTH)
// through the single read port of the table memory, one entry per cycle; a key
// hit ends the scan early.
// Release: the S_RELEASE state sets the strobe, which is registered in rsp_valid_ff.
// busy stays high until the result is produced; the receiver cannot stall.
// Reset frees all entries at once through the live bits; no clearing pass.
module refcounted_context_pool
   import rcp_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request word
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_op,
   input  logic [KEY_W-1:0]       req_team_key,
   input  logic [DATA_W-1:0]      req_team_base,
   input  logic [DATA_W-1:0]      req_team_stride,
   input  logic [DATA_W-1:0]      req_team_size,
   input  logic [IDX_OUT_W-1:0]   req_release_index,
   // response word
   output logic                   rsp_valid,
   output logic [IDX_OUT_W-1:0]   rsp_entry_index,
   output logic [DATA_W-1:0]      rsp_ref_count,
   output logic                   rsp_newly_allocated,
   output logic [DATA_W-1:0]      rsp_entry_base,
   output logic [DATA_W-1:0]      rsp_entry_stride,
   output logic [DATA_W-1:0]      rsp_entry_size,
   output logic [STATUS_W-1:0]    rsp_status,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [POOL_SIZE_W-1:0] csr_pool_size
);

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

   // control state
   state_type               state_ff, state_in;
   logic [POOL_SIZE_W-1:0]  pool_size_ff;
   logic [POOL_DEPTH-1:0]   live_ff, live_in;
   logic [POOL_SIZE_W-1:0]  scan_idx_ff, scan_idx_in;
   logic                    pend_ff, pend_in;
   logic                    pend_live_ff, pend_live_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    rel_ok_ff, rel_ok_in;

   // request payload
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [DATA_W-1:0]       base_ff, base_in;
   logic [DATA_W-1:0]       stride_ff, stride_in;
   logic [DATA_W-1:0]       size_ff, size_in;
   logic [IDX_OUT_W-1:0]    rel_idx_ff, rel_idx_in;

   // response registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                    rsp_new_ff, rsp_new_in;
   logic [DATA_W-1:0]       rsp_start_ff, rsp_start_in;
   logic [DATA_W-1:0]       rsp_stride_ff, rsp_stride_in;
   logic [DATA_W-1:0]       rsp_size_ff, rsp_size_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // table memory
   entry_type               pool_mem [POOL_DEPTH];
   entry_type               rd_entry_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_entry;

   logic [POOL_SIZE_W-1:0]  slots_used;
   logic                    key_hit;
   logic [DATA_W-1:0]       count_inc;
   logic [DATA_W-1:0]       count_dec;

   // limit the entries in use to the table depth
   always_comb begin
      if (int'(pool_size_ff) > POOL_DEPTH) begin
         slots_used = POOL_SIZE_W'(POOL_DEPTH);
      end else begin
         slots_used = pool_size_ff;
      end
   end

   // shared compare and count unit on the word read last cycle
   assign key_hit   = pend_ff && pend_live_ff && (rd_entry_ff.key == key_ff);
   assign count_inc = DATA_W'(rd_entry_ff.count + COUNT_ONE);
   assign count_dec = DATA_W'(rd_entry_ff.count - COUNT_ONE);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      live_in        = live_ff;
      scan_idx_in    = scan_idx_ff;
      pend_in        = pend_ff;
      pend_live_in   = pend_live_ff;
      pend_idx_in    = pend_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rel_ok_in      = rel_ok_ff;
      key_in         = key_ff;
      base_in        = base_ff;
      stride_in      = stride_ff;
      size_in        = size_ff;
      rel_idx_in     = rel_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_stride_in  = rsp_stride_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = IDX_W'(scan_idx_ff);
      wr_en          = 1'b0;
      wr_addr        = pend_idx_ff;
      wr_entry       = rd_entry_ff;

      case (state_ff)
         S_IDLE: begin
            // read the named entry now so release has it next cycle
            rd_addr = IDX_W'(req_release_index);
            if (start) begin
               key_in        = req_team_key;
               base_in       = req_team_base;
               stride_in     = req_team_stride;
               size_in       = req_team_size;
               rel_idx_in    = req_release_index;
               rel_ok_in     = ({1'b0, req_release_index} < slots_used)
                               && live_ff[IDX_W'(req_release_index)];
               scan_idx_in   = '0;
               pend_in       = 1'b0;
               free_found_in = 1'b0;
               if (req_op == OP_RELEASE) begin
                  state_in = S_RELEASE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (key_hit) begin
               // hit: raise the count unless it is saturated
               rsp_valid_in  = 1'b1;
               rsp_index_in  = IDX_OUT_W'(pend_idx_ff);
               rsp_new_in    = 1'b0;
               rsp_start_in  = rd_entry_ff.base;
               rsp_stride_in = rd_entry_ff.stride;
               rsp_size_in   = rd_entry_ff.size;
               if (rd_entry_ff.count == COUNT_MAX) begin
                  rsp_count_in  = rd_entry_ff.count;
                  rsp_status_in = ST_SATURATED;
               end else begin
                  wr_en          = 1'b1;
                  wr_addr        = pend_idx_ff;
                  wr_entry.count = count_inc;
                  rsp_count_in   = count_inc;
                  rsp_status_in  = ST_OK;
               end
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end else if (scan_idx_ff < slots_used) begin
               // issue the next read and note the first free entry
               pend_in      = 1'b1;
               pend_idx_in  = IDX_W'(scan_idx_ff);
               pend_live_in = live_ff[IDX_W'(scan_idx_ff)];
               if (!live_ff[IDX_W'(scan_idx_ff)] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = IDX_W'(scan_idx_ff);
               end
               scan_idx_in = POOL_SIZE_W'(scan_idx_ff + 1'b1);
            end else begin
               // scan done without a hit: claim a free entry or report full
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               if (free_found_ff) begin
                  wr_en                      = 1'b1;
                  wr_addr                    = free_idx_ff;
                  wr_entry.key               = key_ff;
                  wr_entry.count             = COUNT_ONE;
                  wr_entry.base              = base_ff;
                  wr_entry.stride            = stride_ff;
                  wr_entry.size              = size_ff;
                  live_in[free_idx_ff]       = 1'b1;
                  rsp_index_in               = IDX_OUT_W'(free_idx_ff);
                  rsp_count_in               = COUNT_ONE;
                  rsp_new_in                 = 1'b1;
                  rsp_start_in               = base_ff;
                  rsp_stride_in              = stride_ff;
                  rsp_size_in                = size_ff;
                  rsp_status_in              = ST_OK;
               end else begin
                  rsp_index_in  = '0;
                  rsp_count_in  = '0;
                  rsp_new_in    = 1'b0;
                  rsp_start_in  = '0;
                  rsp_stride_in = '0;
                  rsp_size_in   = '0;
                  rsp_status_in = ST_FULL;
               end
               state_in = S_IDLE;
            end
         end

         S_RELEASE: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = rel_idx_ff;
            rsp_new_in   = 1'b0;
            if (!rel_ok_ff) begin
               rsp_count_in  = '0;
               rsp_start_in  = '0;
               rsp_stride_in = '0;
               rsp_size_in   = '0;
               rsp_status_in = ST_BAD_RELEASE;
            end else if (count_dec == '0) begin
               // last reference: drop the entry
               live_in[IDX_W'(rel_idx_ff)] = 1'b0;
               rsp_count_in  = '0;
               rsp_start_in  = '0;
               rsp_stride_in = '0;
               rsp_size_in   = '0;
               rsp_status_in = ST_OK;
            end else begin
               wr_en          = 1'b1;
               wr_addr        = IDX_W'(rel_idx_ff);
               wr_entry.count = count_dec;
               rsp_count_in   = count_dec;
               rsp_start_in   = rd_entry_ff.base;
               rsp_stride_in  = rd_entry_ff.stride;
               rsp_size_in    = rd_entry_ff.size;
               rsp_status_in  = ST_OK;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pool_mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= pool_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_size_ff  <= POOL_SIZE_RESET;
         live_ff       <= '0;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         pend_ff       <= pend_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            pool_size_ff <= csr_pool_size;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      pend_live_ff  <= pend_live_in;
      pend_idx_ff   <= pend_idx_in;
      free_idx_ff   <= free_idx_in;
      rel_ok_ff     <= rel_ok_in;
      key_ff        <= key_in;
      base_ff       <= base_in;
      stride_ff     <= stride_in;
      size_ff       <= size_in;
      rel_idx_ff    <= rel_idx_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_stride_ff <= rsp_stride_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   // drive ports
   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_index     = rsp_index_ff;
   assign rsp_ref_count       = rsp_count_ff;
   assign rsp_newly_allocated = rsp_new_ff;
   assign rsp_entry_base      = rsp_start_ff;
   assign rsp_entry_stride    = rsp_stride_ff;
   assign rsp_entry_size      = rsp_size_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTHESIS
   // one strobe per item, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // an accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // a full pool reports a zero index and count and no new entry
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_entry_index == '0 && rsp_ref_count == '0 && !rsp_newly_allocated))
      else $error("pool full response carries entry data");

   // a fresh entry starts at one reference
   a_new_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_newly_allocated) |->
         (rsp_ref_count == COUNT_ONE && rsp_status == ST_OK))
      else $error("new entry with wrong count or status");
`endif

endmodule

// ===== tb/sv/refcounted_context_pool_tb.sv =====
// Self-checking testbench for refcounted_context_pool: directed table, then random
// acquire/release traffic over several pool sizes, all checked word by word.
// Depends on rcp_pkg and the refcounted_context_pool RTL.
module refcounted_context_pool_tb;
   import rcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = POOL_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_WORDS = 200;

   typedef struct packed {
      logic                 op;
      logic [KEY_W-1:0]     key;
      logic [DATA_W-1:0]    base;
      logic [DATA_W-1:0]    stride;
      logic [DATA_W-1:0]    size;
      logic [IDX_OUT_W-1:0] rel_idx;
   } ctx_req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] idx;
      logic [DATA_W-1:0]    count;
      logic                 fresh;
      logic [DATA_W-1:0]    base;
      logic [DATA_W-1:0]    stride;
      logic [DATA_W-1:0]    size;
      logic [STATUS_W-1:0]  status;
   } ctx_rsp_type;

   typedef enum logic [1:0] {ROW_ACQ, ROW_REL, ROW_CSR} row_kind_type;

   // key doubles as the pool size on a register write row
   typedef struct packed {
      row_kind_type         kind;
      logic [KEY_W-1:0]     key;
      logic [DATA_W-1:0]    base;
      logic [DATA_W-1:0]    stride;
      logic [DATA_W-1:0]    size;
      logic [IDX_OUT_W-1:0] idx;
      logic                 has_rsp;
      ctx_rsp_type          rsp;
   } dir_row_type;

   localparam ctx_rsp_type NO_RSP = '0;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_op = OP_ACQUIRE;
   logic [KEY_W-1:0]       req_team_key = '0;
   logic [DATA_W-1:0]      req_team_base = '0;
   logic [DATA_W-1:0]      req_team_stride = '0;
   logic [DATA_W-1:0]      req_team_size = '0;
   logic [IDX_OUT_W-1:0]   req_release_index = '0;
   logic                   rsp_valid;
   logic [IDX_OUT_W-1:0]   rsp_entry_index;
   logic [DATA_W-1:0]      rsp_ref_count;
   logic                   rsp_newly_allocated;
   logic [DATA_W-1:0]      rsp_entry_base;
   logic [DATA_W-1:0]      rsp_entry_stride;
   logic [DATA_W-1:0]      rsp_entry_size;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_wr_en = 1'b0;
   logic [POOL_SIZE_W-1:0] csr_pool_size = POOL_SIZE_RESET;

   // predicted pool contents and register
   logic [KEY_W-1:0]       pool_key     [DEPTH];
   logic [DATA_W-1:0]      pool_count   [DEPTH];
   logic [DATA_W-1:0]      pool_start   [DEPTH];
   logic [DATA_W-1:0]      pool_stride  [DEPTH];
   logic [DATA_W-1:0]      pool_members [DEPTH];
   logic [POOL_SIZE_W-1:0] pool_size_q = POOL_SIZE_RESET;

   ctx_rsp_type due_rsp_q [$];

   int err_count  = 0;
   int words_sent = 0;
   int rsp_seen   = 0;
   int n_full     = 0;
   int n_bad      = 0;
   int n_sat      = 0;
   int n_csr      = 0;

   dir_row_type dir_tab [0:22] = '{
      // release on an empty pool
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_BAD_RELEASE}},
      // claim with all-ones key and layout, then all-zero key and layout
      '{ROW_ACQ, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 1'b1,
        '{4'd0, 16'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, ST_OK}},
      '{ROW_ACQ, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd1, 16'd1, 1'b1, 16'h0, 16'h0, 16'h0, ST_OK}},
      // hit keeps the stored layout
      '{ROW_ACQ, 32'hFFFF_FFFF, 16'h1, 16'h2, 16'h3, 4'd0, 1'b1,
        '{4'd0, 16'd2, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, ST_OK}},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd15, 1'b1,
        '{4'd15, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_BAD_RELEASE}},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP},
      // release to zero clears the entry
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_OK}},
      '{ROW_ACQ, 32'hA5A5_5A5A, 16'h1234, 16'h00FF, 16'hFF00, 4'd0, 1'b0, NO_RSP},
      // one entry in use: entry 1 is out of reach
      '{ROW_CSR, 32'd1, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP},
      '{ROW_ACQ, 32'h0, 16'h5555, 16'hAAAA, 16'h5555, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_FULL}},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd1, 1'b1,
        '{4'd1, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_BAD_RELEASE}},
      // no entry in use at all
      '{ROW_CSR, 32'd0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP},
      '{ROW_ACQ, 32'hA5A5_5A5A, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_FULL}},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_BAD_RELEASE}},
      // oversize register: entry 1 comes back with its old contents
      '{ROW_CSR, 32'd31, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP},
      '{ROW_ACQ, 32'h0, 16'h9, 16'h9, 16'h9, 4'd0, 1'b0, NO_RSP},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd1, 1'b0, NO_RSP},
      '{ROW_REL, 32'h0, 16'h0, 16'h0, 16'h0, 4'd1, 1'b0, NO_RSP},
      '{ROW_CSR, 32'd2, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP},
      '{ROW_ACQ, 32'h5A5A_A5A5, 16'h8000, 16'h4000, 16'h0001, 4'd0, 1'b0, NO_RSP},
      '{ROW_ACQ, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1,
        '{4'd0, 16'd0, 1'b0, 16'h0, 16'h0, 16'h0, ST_FULL}},
      '{ROW_ACQ, 32'h5A5A_A5A5, 16'h7FFF, 16'hBFFF, 16'hFFFE, 4'd0, 1'b0, NO_RSP},
      '{ROW_CSR, 32'd16, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0, NO_RSP}
   };

   refcounted_context_pool u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_team_key        (req_team_key),
      .req_team_base       (req_team_base),
      .req_team_stride     (req_team_stride),
      .req_team_size       (req_team_size),
      .req_release_index   (req_release_index),
      .rsp_valid           (rsp_valid),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_ref_count       (rsp_ref_count),
      .rsp_newly_allocated (rsp_newly_allocated),
      .rsp_entry_base      (rsp_entry_base),
      .rsp_entry_stride    (rsp_entry_stride),
      .rsp_entry_size      (rsp_entry_size),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_pool_size       (csr_pool_size)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // entries in use: register limited to the pool depth
   function automatic int pool_limit();
      return (int'(pool_size_q) < DEPTH) ? int'(pool_size_q) : DEPTH;
   endfunction

   function automatic ctx_rsp_type entry_view(input int i, input logic fresh,
                                              input logic [STATUS_W-1:0] st);
      ctx_rsp_type r;
      r.idx      = i[IDX_OUT_W-1:0];
      r.count    = pool_count[i];
      r.fresh    = fresh;
      r.base     = pool_start[i];
      r.stride   = pool_stride[i];
      r.size     = pool_members[i];
      r.status   = st;
      return r;
   endfunction

   // advance the predicted pool by one request word
   task automatic pool_apply(input ctx_req_type w, output ctx_rsp_type r);
      int n;
      int hit;
      int slot;
      int ri;
      n    = pool_limit();
      hit  = -1;
      slot = -1;
      r    = '0;
      if (w.op == OP_ACQUIRE) begin
         for (int i = 0; i < n; i++) begin
            if (pool_count[i] != '0 && pool_key[i] == w.key && hit < 0) hit = i;
            if (pool_count[i] == '0 && slot < 0) slot = i;
         end
         if (hit >= 0) begin
            if (pool_count[hit] == COUNT_MAX) begin
               r = entry_view(hit, 1'b0, ST_SATURATED);
            end else begin
               pool_count[hit] = pool_count[hit] + 1'b1;
               r = entry_view(hit, 1'b0, ST_OK);
            end
         end else if (slot >= 0) begin
            pool_key[slot]     = w.key;
            pool_start[slot]   = w.base;
            pool_stride[slot]  = w.stride;
            pool_members[slot] = w.size;
            pool_count[slot]   = COUNT_ONE;
            r = entry_view(slot, 1'b1, ST_OK);
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         ri = int'(w.rel_idx);
         if (ri >= n || pool_count[ri] == '0) begin
            r.idx    = w.rel_idx;
            r.status = ST_BAD_RELEASE;
         end else begin
            pool_count[ri] = pool_count[ri] - 1'b1;
            if (pool_count[ri] == '0) begin
               pool_key[ri]     = '0;
               pool_start[ri]   = '0;
               pool_stride[ri]  = '0;
               pool_members[ri] = '0;
            end
            r = entry_view(ri, 1'b0, ST_OK);
         end
      end
   endtask

   // offer one request word after a gap, keep start high across back-to-back words
   task automatic send_word(input ctx_req_type w, input int gap, input logic typed,
                            input ctx_rsp_type typed_rsp);
      ctx_rsp_type pred;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op            <= w.op;
      req_team_key      <= w.key;
      req_team_base     <= w.base;
      req_team_stride   <= w.stride;
      req_team_size     <= w.size;
      req_release_index <= w.rel_idx;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      pool_apply(w, pred);
      if (typed) pred = typed_rsp;
      due_rsp_q.push_back(pred);
      words_sent++;
      case (pred.status)
         ST_FULL:        n_full++;
         ST_BAD_RELEASE: n_bad++;
         ST_SATURATED:   n_sat++;
         default: ;
      endcase
   endtask

   // drain the block, then write the pool size register
   task automatic write_pool_size(input logic [POOL_SIZE_W-1:0] v);
      if (start) start <= 1'b0;
      @(posedge clock);
      while (due_rsp_q.size() != 0 || busy) @(posedge clock);
      csr_pool_size <= v;
      csr_wr_en     <= 1'b1;
      @(posedge clock);
      pool_size_q = v;
      csr_wr_en <= 1'b0;
      n_csr++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      ctx_rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_rsp_q.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual index %0h status %0h",
                     $time, rsp_entry_index, rsp_status);
            err_count++;
         end else begin
            want = due_rsp_q.pop_front();
            rsp_seen++;
            check_field("entry_index", 32'(want.idx), 32'(rsp_entry_index));
            check_field("ref_count", 32'(want.count), 32'(rsp_ref_count));
            check_field("newly_allocated", 32'(want.fresh), 32'(rsp_newly_allocated));
            check_field("entry_base", 32'(want.base), 32'(rsp_entry_base));
            check_field("entry_stride", 32'(want.stride), 32'(rsp_entry_stride));
            check_field("entry_size", 32'(want.size), 32'(rsp_entry_size));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // hard stop if the block hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d responses outstanding",
               CYCLE_LIMIT, due_rsp_q.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      ctx_req_type            w;
      logic [KEY_W-1:0]       keyset [6];
      logic [POOL_SIZE_W-1:0] phase_sizes [9];
      int                     live [$];
      logic                   no_idle;
      int                     dir_words;

      for (int i = 0; i < DEPTH; i++) begin
         pool_key[i]     = '0;
         pool_count[i]   = '0;
         pool_start[i]   = '0;
         pool_stride[i]  = '0;
         pool_members[i] = '0;
      end
      phase_sizes = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd17, 5'd2, 5'd16};
      phase_sizes[6] = 5'($urandom_range(1, 31));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_tab[r]) begin
         if (dir_tab[r].kind == ROW_CSR) begin
            write_pool_size(dir_tab[r].key[POOL_SIZE_W-1:0]);
         end else begin
            w.op       = (dir_tab[r].kind == ROW_REL) ? OP_RELEASE : OP_ACQUIRE;
            w.key      = dir_tab[r].key;
            w.base     = dir_tab[r].base;
            w.stride   = dir_tab[r].stride;
            w.size     = dir_tab[r].size;
            w.rel_idx  = dir_tab[r].idx;
            send_word(w, $urandom_range(0, 13), dir_tab[r].has_rsp, dir_tab[r].rsp);
         end
      end
      dir_words = words_sent;

      // random traffic: mostly keys from a small set so hits and fills happen
      foreach (phase_sizes[p]) begin
         write_pool_size(phase_sizes[p]);
         foreach (keyset[k]) keyset[k] = $urandom;
         no_idle = 1'b0;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            w.op       = ($urandom_range(0, 99) < 45) ? OP_RELEASE : OP_ACQUIRE;
            w.key      = ($urandom_range(0, 4) == 0) ? $urandom : keyset[$urandom_range(0, 5)];
            w.base     = 16'($urandom);
            w.stride   = 16'($urandom);
            w.size     = 16'($urandom);
            live.delete();
            for (int i = 0; i < pool_limit(); i++)
               if (pool_count[i] != '0) live.push_back(i);
            if (live.size() > 0 && $urandom_range(0, 9) < 7)
               w.rel_idx = 4'(live[$urandom_range(0, live.size() - 1)]);
            else
               w.rel_idx = 4'($urandom_range(0, 15));
            send_word(w, no_idle ? 0 : $urandom_range(0, 13), 1'b0, NO_RSP);
         end
      end

      // drain, then give any stray strobe time to show
      start <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);

      $display("Covered %0d request words (%0d directed) over %0d pool size writes",
               words_sent, dir_words, n_csr);
      $display("Checked %0d responses: %0d pool full, %0d bad release, %0d saturated",
               rsp_seen, n_full, n_bad, n_sat);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
